// ===== hdl/pcsl_pkg.sv =====
// Shared constants and types for the polygon clip / split block.
`default_nettype none
package pcsl_pkg;
    localparam int MAX_VERTS = 16;
    localparam int IDX_W     = $clog2(MAX_VERTS);
    localparam int CNT_W     = $clog2(MAX_VERTS + 1);
    localparam int OCNT_W    = 6;
    localparam int DIST_W    = 36;
    localparam int ADDR_W    = 5;

    localparam logic signed [17:0] ONE_Q16     = 18'sd65536;
    localparam logic signed [17:0] NEG_ONE_Q16 = -18'sd65536;

    localparam logic [2:0] REG_LINE_A   = 3'd0;
    localparam logic [2:0] REG_LINE_B   = 3'd1;
    localparam logic [2:0] REG_LINE_C   = 3'd2;
    localparam logic [2:0] REG_EPSILON  = 3'd3;
    localparam logic [2:0] REG_KEEP_ON  = 3'd4;
    localparam logic [2:0] REG_SPLIT    = 3'd5;

    typedef enum logic [1:0] {
        SIDE_POS = 2'd0,
        SIDE_NEG = 2'd1,
        SIDE_ON  = 2'd2
    } t_side;

    typedef enum logic [1:0] {
        OUT_CROSSED  = 2'd0,
        OUT_FRONT    = 2'd1,
        OUT_BACK     = 2'd2,
        OUT_OVERFLOW = 2'd3
    } t_outcome;
endpackage
`default_nettype wire

// ===== hdl/polygon_clip_split_by_line.sv =====
// Polygon clip / split against one configured line, one vertex word per handshake.
// Vertex words enter on the input channel (i_in_valid / o_in_stall); the word with
// i_last_vertex set closes the polygon. Up to 16 vertices are stored, more are dropped
// and the original comes back with the overflow outcome. After closing, the input is
// stalled while one sequencer with one shared 18x34 multiplier classifies each vertex,
// counts the pieces in one walk, then emits the original or walks again for each piece.
// Each crossing takes one restoring division to a 32-bit fraction, then a low and a
// high multiply and a finishing step per coordinate. Results leave through an output
// register on o_out_valid / i_out_stall; a stalled result holds and the sequencer
// waits for it. The input is accepted again when the sequencer returns to its load
// state after the last result is loaded. Line coefficients are written through the
// APB port; the user must write them only while the block is idle; the block does
// not enforce it. Reset (i_rst_n low, synchronous) empties the vertex store, clears
// the output and restores the register defaults.
`default_nettype none
module polygon_clip_split_by_line (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       psel,
    input  wire                       penable,
    input  wire                       pwrite,
    input  wire [pcsl_pkg::ADDR_W-1:0] paddr,
    input  wire [31:0]                pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  wire signed [31:0]         i_vert_x,
    input  wire signed [31:0]         i_vert_y,
    input  wire                       i_last_vertex,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output logic signed [31:0]        o_out_x,
    output logic signed [31:0]        o_out_y,
    output logic                      o_vertex_valid,
    output logic                      o_piece,
    output logic [1:0]                o_outcome,
    output logic                      o_last_result
);
    import pcsl_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD, S_C_RD, S_C_MA, S_C_MB, S_C_WR, S_DECIDE, S_O_RD, S_O_EM, S_MARK,
        S_W_RDI, S_W_RDN, S_W_EVAL, S_W_VTX, S_CR_INIT, S_DIV, S_M_LO, S_M_HI,
        S_M_FIN, S_CR_EM, S_W_NEXT
    } t_state;

    typedef enum logic [1:0] {
        P_COUNT = 2'd0,
        P_FRONT = 2'd1,
        P_BACK  = 2'd2
    } t_pass;

    t_state r_state;
    t_pass  r_pass;

    logic signed [17:0] r_a, r_b;
    logic signed [31:0] r_c;
    logic [30:0]        r_eps;
    logic               r_keep, r_split;

    logic [63:0]               r_vmem [MAX_VERTS];
    logic [DIST_W+1:0]         r_dmem [MAX_VERTS];
    logic [63:0]               r_vrd;
    logic [DIST_W+1:0]         r_drd;
    logic [IDX_W-1:0]          w_raddr;

    logic [CNT_W-1:0]  r_cnt, r_cf, r_cb;
    logic              r_drop;
    logic [IDX_W-1:0]  r_i;
    logic [OCNT_W-1:0] r_nf, r_nb, r_ktot, r_ecnt;
    logic              r_lim_hit;
    logic              r_orig_piece;
    logic [1:0]        r_orig_oc;

    logic signed [51:0] r_sum;
    logic [65:0]        r_acc;

    logic [63:0]        r_vi;
    logic [DIST_W-1:0]  r_di;
    t_side              r_si;
    logic               r_cross;
    logic signed [31:0] r_p0x, r_p0y, r_p1x, r_p1y;
    logic [DIST_W-1:0]  r_m0, r_m1;
    logic [DIST_W:0]    r_den;
    logic [DIST_W+1:0]  r_rem;
    logic [31:0]        r_t;
    logic [4:0]         r_k;
    logic [32:0]        r_dxm, r_dym;
    logic               r_dxn, r_dyn;
    logic               r_axis;
    logic signed [31:0] r_cx, r_cy;

    logic               r_ov, r_ovv, r_opc, r_olast;
    logic signed [31:0] r_ox, r_oy;
    logic [1:0]         r_ooc;

    logic                   w_wr, w_ofree, w_in_acc, w_ilast;
    logic [IDX_W-1:0]       w_nx;
    logic signed [17:0]     w_op1;
    logic signed [33:0]     w_op2;
    logic signed [51:0]     w_prod;
    logic signed [51:0]     w_full;
    logic signed [DIST_W-1:0] w_d;
    logic signed [DIST_W-1:0] w_eps;
    t_side                  w_side;
    t_side                  w_sn;
    logic [DIST_W-1:0]      w_mi, w_mn;
    logic [DIST_W+1:0]      w_rsh;
    logic [33:0]            w_m;
    logic signed [33:0]     w_res;
    logic signed [17:0]     w_coef;
    logic signed [31:0]     w_p0, w_coord;
    logic signed [32:0]     w_dx, w_dy;
    logic                   w_emit_v;
    logic [OCNT_W-1:0]      w_nf_add, w_nb_add, w_lim;

    assign pready   = 1'b1;
    assign w_wr     = psel & penable & pwrite;
    assign w_ofree  = !r_ov || !i_out_stall;
    assign w_in_acc = i_in_valid && (r_state == S_LOAD);
    assign w_ilast  = ({1'b0, r_i} == r_cnt - CNT_W'(1));
    assign w_nx     = w_ilast ? '0 : r_i + IDX_W'(1);
    assign w_raddr  = (r_state == S_W_RDN) ? w_nx : r_i;

    always_comb begin
        case (paddr[4:2])
            REG_LINE_A:  prdata = {{14{r_a[17]}}, r_a};
            REG_LINE_B:  prdata = {{14{r_b[17]}}, r_b};
            REG_LINE_C:  prdata = r_c;
            REG_EPSILON: prdata = {1'b0, r_eps};
            REG_KEEP_ON: prdata = {31'd0, r_keep};
            REG_SPLIT:   prdata = {31'd0, r_split};
            default:     prdata = 32'd0;
        endcase
    end

    always_comb begin
        case (r_state)
            S_C_MA: begin
                w_op1 = r_a;
                w_op2 = {{2{r_vrd[63]}}, r_vrd[63:32]};
            end
            S_C_MB: begin
                w_op1 = r_b;
                w_op2 = {{2{r_vrd[31]}}, r_vrd[31:0]};
            end
            S_M_LO: begin
                w_op1 = {2'b0, r_t[15:0]};
                w_op2 = {1'b0, r_axis ? r_dym : r_dxm};
            end
            S_M_HI: begin
                w_op1 = {2'b0, r_t[31:16]};
                w_op2 = {1'b0, r_axis ? r_dym : r_dxm};
            end
            default: begin
                w_op1 = '0;
                w_op2 = '0;
            end
        endcase
    end
    assign w_prod = w_op1 * w_op2;

    assign w_full = r_sum + {{4{r_c[31]}}, r_c, 16'd0};
    assign w_d    = w_full[51:16];
    assign w_eps  = {5'd0, r_eps};
    always_comb begin
        if (w_d > w_eps) begin
            w_side = SIDE_POS;
        end else if (w_d < -w_eps) begin
            w_side = SIDE_NEG;
        end else begin
            w_side = SIDE_ON;
        end
    end

    assign w_sn = t_side'(r_drd[DIST_W+1:DIST_W]);
    assign w_mi = r_di[DIST_W-1] ? -r_di : r_di;
    assign w_mn = r_drd[DIST_W-1] ? -r_drd[DIST_W-1:0] : r_drd[DIST_W-1:0];
    assign w_rsh = {r_rem[DIST_W:0], 1'b0};
    assign w_dx = {r_p1x[31], r_p1x} - {r_p0x[31], r_p0x};
    assign w_dy = {r_p1y[31], r_p1y} - {r_p0y[31], r_p0y};

    assign w_m    = r_acc[65:32] + {33'd0, r_acc[31]};
    assign w_p0   = r_axis ? r_p0y : r_p0x;
    assign w_coef = r_axis ? r_b : r_a;
    assign w_res  = (r_axis ? r_dyn : r_dxn) ? {{2{w_p0[31]}}, w_p0} - $signed(w_m)
                                              : {{2{w_p0[31]}}, w_p0} + $signed(w_m);
    always_comb begin
        if (w_coef == ONE_Q16) begin
            w_coord = (r_c == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -r_c;
        end else if (w_coef == NEG_ONE_Q16) begin
            w_coord = r_c;
        end else begin
            w_coord = w_res[31:0];
        end
    end

    assign w_emit_v = (r_pass == P_BACK) ? (r_si != SIDE_POS) : (r_si != SIDE_NEG);
    assign w_nf_add = OCNT_W'(r_si != SIDE_NEG) + OCNT_W'(r_cross);
    assign w_nb_add = OCNT_W'(r_si != SIDE_POS) + OCNT_W'(r_cross);
    assign w_lim    = OCNT_W'(r_cnt) + OCNT_W'(4);

    always_ff @(posedge i_clk) begin
        if (w_in_acc && r_cnt < CNT_W'(MAX_VERTS)) begin
            r_vmem[r_cnt[IDX_W-1:0]] <= {i_vert_x, i_vert_y};
        end
        r_vrd <= r_vmem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_C_WR) begin
            r_dmem[r_i] <= {w_side, w_d};
        end
        r_drd <= r_dmem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_pass  <= P_COUNT;
            r_a     <= '0;
            r_b     <= '0;
            r_c     <= '0;
            r_eps   <= 31'd6554;
            r_keep  <= 1'b0;
            r_split <= 1'b0;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_ov    <= 1'b0;
            r_i     <= '0;
            r_ecnt  <= '0;
            r_ktot  <= '0;
            r_cf    <= '0;
            r_cb    <= '0;
        end else begin
            if (w_wr) begin
                case (paddr[4:2])
                    REG_LINE_A:  r_a     <= pwdata[17:0];
                    REG_LINE_B:  r_b     <= pwdata[17:0];
                    REG_LINE_C:  r_c     <= pwdata;
                    REG_EPSILON: r_eps   <= pwdata[30:0];
                    REG_KEEP_ON: r_keep  <= pwdata[0];
                    REG_SPLIT:   r_split <= pwdata[0];
                    default: ;
                endcase
            end
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (r_cnt < CNT_W'(MAX_VERTS)) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_last_vertex) begin
                            r_i     <= '0;
                            r_cf    <= '0;
                            r_cb    <= '0;
                            r_state <= S_C_RD;
                        end
                    end
                end
                S_C_RD: r_state <= S_C_MA;
                S_C_MA: begin
                    r_sum   <= w_prod;
                    r_state <= S_C_MB;
                end
                S_C_MB: begin
                    r_sum   <= r_sum + w_prod;
                    r_state <= S_C_WR;
                end
                S_C_WR: begin
                    if (w_side == SIDE_POS) begin
                        r_cf <= r_cf + CNT_W'(1);
                    end
                    if (w_side == SIDE_NEG) begin
                        r_cb <= r_cb + CNT_W'(1);
                    end
                    if (w_ilast) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= S_C_RD;
                    end
                end
                S_DECIDE: begin
                    r_i    <= '0;
                    r_ecnt <= '0;
                    r_nf   <= '0;
                    r_nb   <= '0;
                    r_lim_hit <= 1'b0;
                    r_ktot <= OCNT_W'(r_cnt);
                    r_orig_piece <= 1'b0;
                    r_state      <= S_O_RD;
                    if (r_drop) begin
                        r_orig_oc <= OUT_OVERFLOW;
                    end else if (!r_split) begin
                        if (r_keep && r_cf == '0 && r_cb == '0) begin
                            r_orig_oc <= OUT_FRONT;
                        end else if (r_cf == '0) begin
                            r_ktot  <= OCNT_W'(1);
                            r_state <= S_MARK;
                        end else if (r_cb == '0) begin
                            r_orig_oc <= OUT_FRONT;
                        end else begin
                            r_pass  <= P_COUNT;
                            r_state <= S_W_RDI;
                        end
                    end else begin
                        if (r_cf == '0) begin
                            r_orig_piece <= 1'b1;
                            r_orig_oc    <= OUT_BACK;
                        end else if (r_cb == '0) begin
                            r_orig_oc <= OUT_FRONT;
                        end else begin
                            r_pass  <= P_COUNT;
                            r_state <= S_W_RDI;
                        end
                    end
                end
                S_MARK: begin
                    if (w_ofree) begin
                        r_ov    <= 1'b1;
                        r_ox    <= '0;
                        r_oy    <= '0;
                        r_ovv   <= 1'b0;
                        r_opc   <= 1'b0;
                        r_ooc   <= OUT_BACK;
                        r_olast <= 1'b1;
                        r_cnt   <= '0;
                        r_drop  <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                S_O_RD: r_state <= S_O_EM;
                S_O_EM: begin
                    if (w_ofree) begin
                        r_ov    <= 1'b1;
                        r_ox    <= r_vrd[63:32];
                        r_oy    <= r_vrd[31:0];
                        r_ovv   <= 1'b1;
                        r_opc   <= r_orig_piece;
                        r_ooc   <= r_orig_oc;
                        r_olast <= (r_ecnt == r_ktot - OCNT_W'(1));
                        r_ecnt  <= r_ecnt + OCNT_W'(1);
                        if (w_ilast) begin
                            r_cnt   <= '0;
                            r_drop  <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_i     <= r_i + IDX_W'(1);
                            r_state <= S_O_RD;
                        end
                    end
                end
                S_W_RDI: r_state <= S_W_RDN;
                S_W_RDN: begin
                    r_vi    <= r_vrd;
                    r_di    <= r_drd[DIST_W-1:0];
                    r_si    <= t_side'(r_drd[DIST_W+1:DIST_W]);
                    r_state <= S_W_EVAL;
                end
                S_W_EVAL: begin
                    r_cross <= (r_si == SIDE_POS && w_sn == SIDE_NEG) ||
                               (r_si == SIDE_NEG && w_sn == SIDE_POS);
                    if (!r_split || r_si == SIDE_POS) begin
                        r_p0x <= r_vi[63:32];
                        r_p0y <= r_vi[31:0];
                        r_p1x <= r_vrd[63:32];
                        r_p1y <= r_vrd[31:0];
                        r_m0  <= w_mi;
                        r_m1  <= w_mn;
                    end else begin
                        r_p0x <= r_vrd[63:32];
                        r_p0y <= r_vrd[31:0];
                        r_p1x <= r_vi[63:32];
                        r_p1y <= r_vi[31:0];
                        r_m0  <= w_mn;
                        r_m1  <= w_mi;
                    end
                    r_state <= S_W_VTX;
                end
                S_W_VTX: begin
                    if (r_pass == P_COUNT) begin
                        if (r_nf >= w_lim ||
                            (r_cross && r_nf + OCNT_W'(r_si != SIDE_NEG) >= w_lim)) begin
                            r_lim_hit <= 1'b1;
                        end
                        r_nf    <= r_nf + w_nf_add;
                        r_nb    <= r_nb + w_nb_add;
                        r_state <= S_W_NEXT;
                    end else if (!w_emit_v || w_ofree) begin
                        if (w_emit_v) begin
                            r_ov    <= 1'b1;
                            r_ox    <= r_vi[63:32];
                            r_oy    <= r_vi[31:0];
                            r_ovv   <= 1'b1;
                            r_opc   <= (r_pass == P_BACK);
                            r_ooc   <= OUT_CROSSED;
                            r_olast <= (r_ecnt == r_ktot - OCNT_W'(1));
                            r_ecnt  <= r_ecnt + OCNT_W'(1);
                        end
                        r_state <= r_cross ? S_CR_INIT : S_W_NEXT;
                    end
                end
                S_CR_INIT: begin
                    r_den   <= {1'b0, r_m0} + {1'b0, r_m1};
                    r_rem   <= {2'b0, r_m0};
                    r_t     <= '0;
                    r_k     <= '0;
                    r_dxn   <= w_dx[32];
                    r_dyn   <= w_dy[32];
                    r_dxm   <= w_dx[32] ? -w_dx : w_dx;
                    r_dym   <= w_dy[32] ? -w_dy : w_dy;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_rsh >= {1'b0, r_den}) begin
                        r_rem <= w_rsh - {1'b0, r_den};
                        r_t   <= {r_t[30:0], 1'b1};
                    end else begin
                        r_rem <= w_rsh;
                        r_t   <= {r_t[30:0], 1'b0};
                    end
                    r_k <= r_k + 5'd1;
                    if (r_k == 5'd31) begin
                        r_axis  <= 1'b0;
                        r_state <= S_M_LO;
                    end
                end
                S_M_LO: begin
                    r_acc   <= {14'd0, w_prod};
                    r_state <= S_M_HI;
                end
                S_M_HI: begin
                    r_acc   <= r_acc + {w_prod[49:0], 16'd0};
                    r_state <= S_M_FIN;
                end
                S_M_FIN: begin
                    if (r_axis) begin
                        r_cy    <= w_coord;
                        r_state <= S_CR_EM;
                    end else begin
                        r_cx    <= w_coord;
                        r_axis  <= 1'b1;
                        r_state <= S_M_LO;
                    end
                end
                S_CR_EM: begin
                    if (w_ofree) begin
                        r_ov    <= 1'b1;
                        r_ox    <= r_cx;
                        r_oy    <= r_cy;
                        r_ovv   <= 1'b1;
                        r_opc   <= (r_pass == P_BACK);
                        r_ooc   <= OUT_CROSSED;
                        r_olast <= (r_ecnt == r_ktot - OCNT_W'(1));
                        r_ecnt  <= r_ecnt + OCNT_W'(1);
                        r_state <= S_W_NEXT;
                    end
                end
                S_W_NEXT: begin
                    if (!w_ilast) begin
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= S_W_RDI;
                    end else begin
                        r_i <= '0;
                        case (r_pass)
                            P_COUNT: begin
                                if (!r_split) begin
                                    if (r_lim_hit || r_nf >= OCNT_W'(MAX_VERTS)) begin
                                        r_orig_oc <= OUT_OVERFLOW;
                                        r_state   <= S_O_RD;
                                    end else begin
                                        r_ktot  <= r_nf;
                                        r_pass  <= P_FRONT;
                                        r_state <= S_W_RDI;
                                    end
                                end else begin
                                    if (r_nf >= OCNT_W'(MAX_VERTS) ||
                                        r_nb >= OCNT_W'(MAX_VERTS) ||
                                        ({1'b0, r_nf} + {1'b0, r_nb}) > 7'd32) begin
                                        r_orig_oc <= OUT_OVERFLOW;
                                        r_state   <= S_O_RD;
                                    end else begin
                                        r_ktot  <= r_nf + r_nb;
                                        r_pass  <= P_FRONT;
                                        r_state <= S_W_RDI;
                                    end
                                end
                            end
                            P_FRONT: begin
                                if (r_split) begin
                                    r_pass  <= P_BACK;
                                    r_state <= S_W_RDI;
                                end else begin
                                    r_cnt   <= '0;
                                    r_drop  <= 1'b0;
                                    r_state <= S_LOAD;
                                end
                            end
                            default: begin
                                r_cnt   <= '0;
                                r_drop  <= 1'b0;
                                r_state <= S_LOAD;
                            end
                        endcase
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_LOAD);
    assign o_out_valid    = r_ov;
    assign o_out_x        = r_ox;
    assign o_out_y        = r_oy;
    assign o_vertex_valid = r_ovv;
    assign o_piece        = r_opc;
    assign o_outcome      = r_ooc;
    assign o_last_result  = r_olast;
endmodule
`default_nettype wire

// ===== tb/sv/pcsl_checker.sv =====
// Checker for the polygon clip / split block: predicts result words and compares them.
`timescale 1ns / 100ps
`default_nettype none
module pcsl_checker (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [pcsl_pkg::ADDR_W-1:0]  paddr,
    input  wire [31:0]                  pwdata,
    input  wire                         i_in_valid,
    input  wire                         o_in_stall,
    input  wire signed [31:0]           i_vert_x,
    input  wire signed [31:0]           i_vert_y,
    input  wire                         i_last_vertex,
    input  wire                         o_out_valid,
    input  wire                         i_out_stall,
    input  wire signed [31:0]           o_out_x,
    input  wire signed [31:0]           o_out_y,
    input  wire                         o_vertex_valid,
    input  wire                         o_piece,
    input  wire [1:0]                   o_outcome,
    input  wire                         o_last_result,
    output int                          o_fail_count,
    output int                          o_pending
);
    import pcsl_pkg::*;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        vv;
        logic        piece;
        logic [1:0]  outcome;
        logic        last;
    } t_rvert;

    t_rvert vert_q[$];

    logic signed [17:0] coef_a, coef_b;
    logic signed [31:0] coef_c;
    logic [30:0]        eps;
    logic               keep_on, split_on;

    logic signed [31:0] poly_x[MAX_VERTS], poly_y[MAX_VERTS];
    logic signed [47:0] vdist[MAX_VERTS];
    t_side              side[MAX_VERTS];
    int                 nverts;
    bit                 overflowed;
    int                 fails = 0;

    assign o_pending    = vert_q.size();
    assign o_fail_count = fails;

    function automatic logic signed [31:0] axis_pt(logic signed [17:0] cf,
            logic signed [31:0] p0, logic signed [31:0] p1, logic [31:0] t);
        logic signed [33:0] delta;
        logic [32:0]        dm;
        logic [64:0]        prod;
        logic [33:0]        m;
        if (cf == ONE_Q16)
            return (coef_c == 32'sh8000_0000) ? 32'sh7fff_ffff : -coef_c;
        if (cf == NEG_ONE_Q16)
            return coef_c;
        delta = 34'(p1) - 34'(p0);
        dm = delta < 0 ? 33'(-delta) : 33'(delta);
        prod = 65'(t) * 65'(dm);
        m = 34'(prod >> 32) + 34'(prod[31]);
        return delta < 0 ? 32'(34'(p0) - m) : 32'(34'(p0) + m);
    endfunction

    function automatic void cross_pt(int i0, int i1, output logic signed [31:0] cx,
            output logic signed [31:0] cy);
        logic [48:0] m0, den, r;
        logic [31:0] t;
        m0 = vdist[i0] < 0 ? 49'(-vdist[i0]) : 49'(vdist[i0]);
        den = m0 + (vdist[i1] < 0 ? 49'(-vdist[i1]) : 49'(vdist[i1]));
        r = m0;
        t = 0;
        for (int k = 0; k < 32; k++) begin
            r = r << 1;
            t = t << 1;
            if (r >= den) begin
                r = r - den;
                t[0] = 1'b1;
            end
        end
        cx = axis_pt(coef_a, poly_x[i0], poly_x[i1], t);
        cy = axis_pt(coef_b, poly_y[i0], poly_y[i1], t);
    endfunction

    function automatic void push_orig(bit pc, t_outcome oc);
        for (int i = 0; i < nverts; i++)
            vert_q.push_back('{poly_x[i], poly_y[i], 1'b1, pc, oc, 1'b0});
    endfunction

    task automatic close_polygon();
        int cnt[3];
        int q0, nn, nf, nb;
        bit fallback;
        logic signed [31:0] fx[$], fy[$], bx[$], by[$];
        logic signed [31:0] cx, cy;
        logic signed [63:0] acc;
        int nx;
        cnt = '{0, 0, 0};
        q0 = vert_q.size();
        fallback = 0;
        for (int i = 0; i < nverts; i++) begin
            acc = 64'(coef_a) * 64'(poly_x[i]) + 64'(coef_b) * 64'(poly_y[i])
                + (64'(coef_c) <<< 16);
            vdist[i] = 48'(acc >>> 16);
            side[i] = vdist[i] > $signed({17'd0, eps}) ? SIDE_POS :
                      (vdist[i] < -$signed({17'd0, eps}) ? SIDE_NEG : SIDE_ON);
            cnt[side[i]]++;
        end
        if (overflowed)
            push_orig(0, OUT_OVERFLOW);
        else if (!split_on) begin
            if (keep_on && cnt[SIDE_POS] == 0 && cnt[SIDE_NEG] == 0)
                push_orig(0, OUT_FRONT);
            else if (cnt[SIDE_POS] == 0)
                vert_q.push_back('{32'd0, 32'd0, 1'b0, 1'b0, OUT_BACK, 1'b0});
            else if (cnt[SIDE_NEG] == 0)
                push_orig(0, OUT_FRONT);
            else begin
                for (int i = 0; i < nverts && !fallback; i++) begin
                    nx = (i + 1) % nverts;
                    if (fx.size() >= nverts + 4) begin
                        fallback = 1;
                    end else begin
                        if (side[i] != SIDE_NEG) begin
                            fx.push_back(poly_x[i]);
                            fy.push_back(poly_y[i]);
                        end
                        if (!(side[i] == SIDE_ON || side[nx] == SIDE_ON
                              || side[nx] == side[i])) begin
                            if (fx.size() >= nverts + 4)
                                fallback = 1;
                            else begin
                                cross_pt(i, nx, cx, cy);
                                fx.push_back(cx);
                                fy.push_back(cy);
                            end
                        end
                    end
                end
                if (fallback || fx.size() >= MAX_VERTS)
                    push_orig(0, OUT_OVERFLOW);
                else
                    foreach (fx[i])
                        vert_q.push_back('{fx[i], fy[i], 1'b1, 1'b0, OUT_CROSSED, 1'b0});
            end
        end else begin
            if (cnt[SIDE_POS] == 0)
                push_orig(1, OUT_BACK);
            else if (cnt[SIDE_NEG] == 0)
                push_orig(0, OUT_FRONT);
            else begin
                for (int i = 0; i < nverts; i++) begin
                    nx = (i + 1) % nverts;
                    if (side[i] != SIDE_NEG) begin
                        fx.push_back(poly_x[i]);
                        fy.push_back(poly_y[i]);
                    end
                    if (side[i] != SIDE_POS) begin
                        bx.push_back(poly_x[i]);
                        by.push_back(poly_y[i]);
                    end
                    if (!(side[i] == SIDE_ON || side[nx] == SIDE_ON
                          || side[nx] == side[i])) begin
                        if (side[i] == SIDE_POS)
                            cross_pt(i, nx, cx, cy);
                        else
                            cross_pt(nx, i, cx, cy);
                        fx.push_back(cx);
                        fy.push_back(cy);
                        bx.push_back(cx);
                        by.push_back(cy);
                    end
                end
                nf = fx.size();
                nb = bx.size();
                if (nf >= MAX_VERTS || nb >= MAX_VERTS || nf + nb > 32)
                    push_orig(0, OUT_OVERFLOW);
                else begin
                    foreach (fx[i])
                        vert_q.push_back('{fx[i], fy[i], 1'b1, 1'b0, OUT_CROSSED, 1'b0});
                    foreach (bx[i])
                        vert_q.push_back('{bx[i], by[i], 1'b1, 1'b1, OUT_CROSSED, 1'b0});
                end
            end
        end
        nn = vert_q.size();
        if (nn > q0)
            vert_q[nn - 1].last = 1'b1;
    endtask

    task automatic check_word();
        t_rvert e;
        if (vert_q.size() == 0) begin
            $error("unexpected result word x=%h y=%h", o_out_x, o_out_y);
            fails++;
            return;
        end
        e = vert_q.pop_front();
        if (o_vertex_valid != e.vv) begin
            $error("vertex_valid: expected %0d actual %0d", e.vv, o_vertex_valid);
            fails++;
        end
        if (o_out_x != e.x) begin
            $error("out_x: expected %h actual %h", e.x, o_out_x);
            fails++;
        end
        if (o_out_y != e.y) begin
            $error("out_y: expected %h actual %h", e.y, o_out_y);
            fails++;
        end
        if (o_piece != e.piece) begin
            $error("piece: expected %0d actual %0d", e.piece, o_piece);
            fails++;
        end
        if (o_outcome != e.outcome) begin
            $error("outcome: expected %0d actual %0d", e.outcome, o_outcome);
            fails++;
        end
        if (o_last_result != e.last) begin
            $error("last_result: expected %0d actual %0d", e.last, o_last_result);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            coef_a <= '0;
            coef_b <= '0;
            coef_c <= '0;
            eps <= 31'd6554;
            keep_on <= 1'b0;
            split_on <= 1'b0;
            nverts = 0;
            overflowed = 0;
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr[4:2])
                    REG_LINE_A:  coef_a <= pwdata[17:0];
                    REG_LINE_B:  coef_b <= pwdata[17:0];
                    REG_LINE_C:  coef_c <= pwdata;
                    REG_EPSILON: eps <= pwdata[30:0];
                    REG_KEEP_ON: keep_on <= pwdata[0];
                    REG_SPLIT:   split_on <= pwdata[0];
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall)
                check_word();
            if (i_in_valid && !o_in_stall) begin
                if (nverts < MAX_VERTS) begin
                    poly_x[nverts] = i_vert_x;
                    poly_y[nverts] = i_vert_y;
                    nverts++;
                end else
                    overflowed = 1;
                if (i_last_vertex) begin
                    close_polygon();
                    nverts = 0;
                    overflowed = 0;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Top of the testbench: clock, reset, register writes, vertex stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import pcsl_pkg::*;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid = 0;
    logic               o_in_stall;
    logic signed [31:0] i_vert_x = 0, i_vert_y = 0;
    logic               i_last_vertex = 0;
    logic               o_out_valid;
    logic               i_out_stall = 0;
    logic signed [31:0] o_out_x, o_out_y;
    logic               o_vertex_valid, o_piece, o_last_result;
    logic [1:0]         o_outcome;
    int                 fail_count, pending;
    bit                 calm = 0;
    bit                 hold_off = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    polygon_clip_split_by_line i_dut (.*);

    pcsl_checker i_chk (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .i_in_valid, .o_in_stall, .i_vert_x, .i_vert_y, .i_last_vertex,
        .o_out_valid, .i_out_stall, .o_out_x, .o_out_y, .o_vertex_valid,
        .o_piece, .o_outcome, .o_last_result,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random stall bursts, long hold when asked
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
                i_out_stall <= 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 4);
                i_out_stall <= 1;
                repeat (n - 1) @(posedge i_clk);
            end else
                i_out_stall <= 0;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_line(int a, int b, int c, int e, bit keep, bit split);
        drain();
        reg_write(REG_LINE_A, a);
        reg_write(REG_LINE_B, b);
        reg_write(REG_LINE_C, c);
        reg_write(REG_EPSILON, e);
        reg_write(REG_KEEP_ON, keep);
        reg_write(REG_SPLIT, split);
    endtask

    task automatic send_vertex(logic [31:0] x, logic [31:0] y, bit last);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 0;
            n = $urandom_range(1, 4);
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_vert_x <= x;
        i_vert_y <= y;
        i_last_vertex <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_polygon(int n, int span);
        for (int i = 0; i < n; i++)
            send_vertex(span == 0 ? $urandom : $urandom_range(0, 2 * span) - span,
                        span == 0 ? $urandom : $urandom_range(0, 2 * span) - span,
                        i == n - 1);
    endtask

    task automatic random_line();
        int sel;
        sel = $urandom_range(0, 5);
        set_line(sel == 0 ? 65536 : (sel == 1 ? -65536 : $urandom_range(0, 131072) - 65536),
                 sel == 2 ? 65536 : (sel == 3 ? -65536 : $urandom_range(0, 131072) - 65536),
                 sel == 4 ? $urandom : $urandom_range(0, 2000000) - 1000000,
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 2147483647)
                                           : $urandom_range(0, 20000),
                 $urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // square in the middle of x = 0, clip
        set_line(65536, 0, 0, 6554, 0, 0);
        send_vertex(-32'sd65536, -32'sd65536, 0);
        send_vertex(32'sd65536, -32'sd65536, 0);
        send_vertex(32'sd65536, 32'sd65536, 0);
        send_vertex(-32'sd65536, 32'sd65536, 1);
        // all behind: empty marker
        send_vertex(-32'sd100000, 0, 0);
        send_vertex(-32'sd200000, 0, 0);
        send_vertex(-32'sd150000, 32'sd90000, 1);
        // all on the line, kept
        set_line(65536, 0, 0, 6554, 1, 0);
        send_vertex(0, 0, 0);
        send_vertex(0, 32'sd65536, 0);
        send_vertex(1, 32'sd131072, 1);
        // split with extreme coordinates and line
        set_line(-65536, -65536, 32'h8000_0000, 0, 0, 1);
        send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 0);
        send_vertex(32'h8000_0000, 32'h8000_0000, 0);
        send_vertex(32'h8000_0000, 32'h7fff_ffff, 1);
        // too many vertices
        set_line(65536, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
        send_polygon(18, 0);
        // single vertex, all zero coefficients
        set_line(0, 0, 0, 0, 0, 1);
        send_vertex(32'hffff_ffff, 0, 1);
        for (int p = 0; p < 60; p++) begin
            if (p % 8 == 0)
                random_line();
            if (p == 20)
                hold_off = 1;
            if (p == 40)
                drain();
            if (p >= 50)
                calm = 1;
            send_polygon($urandom_range(0, 9) == 0 ? $urandom_range(14, 18)
                                                   : $urandom_range(3, 6),
                         $urandom_range(0, 5) == 0 ? 0 : 300000);
        end
        drain();
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("testbench: errors");
        $finish;
    end
endmodule
`default_nettype wire
